[design/fpcd_pkg.sv]
// Package for the fault pulse code decoder: payload and configuration types,
// status codes, register indexes and reset values. No dependencies.
`default_nettype none

package fpcd_pkg;

	// Configuration port index width; indexes above the register list are ignored
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PULSE_DURATION = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_REPORT_GAP     = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_PULSE_GAP      = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_SLACK          = cfg_idx_t'(3);

	localparam logic [CFG_DATA_W-1:0] RST_PULSE_DURATION = 16'd500;
	localparam logic [CFG_DATA_W-1:0] RST_REPORT_GAP     = 16'd5000;
	localparam logic [CFG_DATA_W-1:0] RST_PULSE_GAP      = 16'd1000;
	localparam logic [CFG_DATA_W-1:0] RST_SLACK          = 16'd100;

	// Reported status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MID      = 2'd1,
		ST_REPORTED = 2'd2,
		ST_ERROR    = 2'd3
	} status_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pulse_duration_ms;
		logic [CFG_DATA_W-1:0] report_gap_ms;
		logic [CFG_DATA_W-1:0] pulse_gap_ms;
		logic [CFG_DATA_W-1:0] slack_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        line_level;
	} sample_t;

	typedef struct packed {
		logic [1:0] cycle_status;
		logic [7:0] fault_code;
		logic [7:0] pulse_count;
	} result_t;

endpackage

`default_nettype wire

[design/fpcd_core.sv]
// Decoder state and combinational update for one line sample.
// Depends on fpcd_pkg (sample, result, config and status types).
`default_nettype none

module fpcd_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire fpcd_pkg::sample_t item,
	input  wire fpcd_pkg::cfg_t    cfg,
	output fpcd_pkg::result_t      result
);

	logic [31:0]       last_change_q;
	logic              prev_level_q;
	logic [7:0]        burst_q;
	fpcd_pkg::status_t status_q;
	logic [7:0]        code_q;

	logic [31:0]       last_change_d;
	logic [7:0]        burst_d;
	fpcd_pkg::status_t status_d;
	logic [7:0]        code_d;

	logic [31:0] elapsed;
	logic [16:0] dur_thr;
	logic [16:0] report_thr;
	logic [16:0] gap_thr;

	// Modular elapsed time and 17-bit thresholds (never wrap)
	assign elapsed    = item.now_ms - last_change_q;
	assign dur_thr    = {1'b0, cfg.pulse_duration_ms} + {1'b0, cfg.slack_ms};
	assign report_thr = {1'b0, cfg.report_gap_ms} + {1'b0, cfg.slack_ms};
	assign gap_thr    = {1'b0, cfg.pulse_gap_ms} + {1'b0, cfg.slack_ms};

	// Next state: edges first, then high timeout, then the two low timeouts
	always_comb begin
		last_change_d = last_change_q;
		burst_d       = burst_q;
		status_d      = status_q;
		code_d        = code_q;
		priority if (item.line_level != prev_level_q) begin
			last_change_d = item.now_ms;
			if (item.line_level) begin
				status_d = fpcd_pkg::ST_MID;
				if (burst_q != 8'hFF) begin
					burst_d = burst_q + 8'd1;
				end
			end
		end else if (item.line_level) begin
			if (elapsed > {15'd0, dur_thr}) begin
				status_d = fpcd_pkg::ST_ERROR;
			end
		end else if (elapsed > {15'd0, report_thr}) begin
			status_d = fpcd_pkg::ST_OK;
			code_d   = 8'd0;
		end else if (elapsed > {15'd0, gap_thr} && burst_q != 8'd0) begin
			status_d = fpcd_pkg::ST_REPORTED;
			code_d   = burst_q;
			burst_d  = 8'd0;
		end
	end

	// State registers, updated once per consumed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_change_q <= '0;
			prev_level_q  <= 1'b0;
			burst_q       <= '0;
			status_q      <= fpcd_pkg::ST_OK;
			code_q        <= '0;
		end else if (step) begin
			last_change_q <= last_change_d;
			prev_level_q  <= item.line_level;
			burst_q       <= burst_d;
			status_q      <= status_d;
			code_q        <= code_d;
		end
	end

	// Result carries the values after the update
	assign result.cycle_status = status_d;
	assign result.fault_code   = code_d;
	assign result.pulse_count  = burst_d;

	// A rising edge always leaves the decoder mid report
	a_rise_mid: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.line_level && !prev_level_q |=> status_q == fpcd_pkg::ST_MID)
		else $error("rising edge did not set mid report");

	// A published code is either cleared or the burst count just before
	a_code_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(code_q) |-> code_q == 8'd0 || code_q == $past(burst_q))
		else $error("fault code changed to an unexpected value");

	// Counter only grows by one or returns to zero
	a_burst_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(burst_q) |-> burst_q == 8'd0 || burst_q == $past(burst_q) + 8'd1)
		else $error("pulse counter moved by more than one");

	// Counter is zeroed only when a code is published
	a_burst_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && burst_q != 8'd0 && burst_d == 8'd0 |-> status_d == fpcd_pkg::ST_REPORTED)
		else $error("pulse counter cleared without a report");

endmodule

`default_nettype wire

[design/fault_pulse_code_decoder.sv]
// Flow: a sample accepted into the sample register gives its result in the result register once
// stage 1 advances. Throughput: one sample per cycle while result_stall does not hold the result
// register; the state update is a combinational loop in fpcd_core between the two registers.
// Reset: arst_n clears all valid flags and decoder state; configuration returns to
// 500 / 5000 / 1000 / 100 ms. cfg_ready is always high.
// Top level of the fault pulse code decoder. Depends on fpcd_pkg and fpcd_core.
`default_nettype none

module fault_pulse_code_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_stall,
	input  wire fpcd_pkg::sample_t               sample,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output fpcd_pkg::result_t                    result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fpcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fpcd_pkg::CFG_DATA_W-1:0] cfg_data
);

	fpcd_pkg::cfg_t    cfg_q;
	fpcd_pkg::sample_t sample_s1;
	logic              valid_s1;
	fpcd_pkg::result_t result_next;
	fpcd_pkg::result_t result_q;
	logic              result_valid_q;
	logic              advance;
	logic              step;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_duration_ms <= fpcd_pkg::RST_PULSE_DURATION;
			cfg_q.report_gap_ms     <= fpcd_pkg::RST_REPORT_GAP;
			cfg_q.pulse_gap_ms      <= fpcd_pkg::RST_PULSE_GAP;
			cfg_q.slack_ms          <= fpcd_pkg::RST_SLACK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fpcd_pkg::CFG_PULSE_DURATION: cfg_q.pulse_duration_ms <= cfg_data;
				fpcd_pkg::CFG_REPORT_GAP:     cfg_q.report_gap_ms     <= cfg_data;
				fpcd_pkg::CFG_PULSE_GAP:      cfg_q.pulse_gap_ms      <= cfg_data;
				fpcd_pkg::CFG_SLACK:          cfg_q.slack_ms          <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Flow control: stage 1 moves on whenever the result slot is free or being taken
	assign advance      = !result_valid_q || !result_stall;
	assign step         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	// Sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	fpcd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (sample_s1),
		.cfg    (cfg_q),
		.result (result_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
